FILE: rtl/kslp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kslp_pkg
// Shared types, widths and codes of the short/long key press detector.
// ----------------------------------------------------------------------------
package kslp_pkg;

    // Defaults for the top level parameters
    localparam int NUM_KEYS_DEF     = 4;
    localparam int TICK_STEP_MS_DEF = 10;

    // Fixed field widths
    localparam int MAX_KEYS   = 4;
    localparam int ACTION_W   = 2;
    localparam int KEY_IDX_W  = 2;
    localparam int LEVELS_W   = MAX_KEYS;
    localparam int CODE_W     = 3;
    localparam int THR_W      = 16;
    localparam int TIME_W     = 17;
    localparam int FLAGS_W    = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    // Event flag bit positions
    localparam int FLAG_FIRST = 0;
    localparam int FLAG_SHOLD = 1;
    localparam int FLAG_SREL  = 2;
    localparam int FLAG_LHOLD = 3;
    localparam int FLAG_LREL  = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CHECK = 2'd2,
        ACT_RESET = 2'd3
    } action_t;

    typedef enum logic [CODE_W-1:0] {
        EVT_NONE   = 3'd0,
        EVT_FIRST  = 3'd1,
        EVT_SHOLD  = 3'd2,
        EVT_SREL   = 3'd3,
        EVT_LHOLD  = 3'd4,
        EVT_LREL   = 3'd5
    } evt_code_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_ENABLE    = 2'd0,
        REG_LONG_MODE = 2'd1,
        REG_SHORT_THR = 2'd2,
        REG_LONG_THR  = 2'd3
    } reg_idx_t;

    // Per-key command for one accepted transfer
    typedef struct packed {
        logic tick;
        logic level;
        logic enable;
        logic long_mode;
        logic read;
        logic clear;
    } key_cmd_t;

endpackage : kslp_pkg
`default_nettype wire

FILE: rtl/kslp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kslp_cmd_if / kslp_rsp_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface kslp_cmd_if;
    import kslp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [KEY_IDX_W-1:0] key_index;
    logic [LEVELS_W-1:0]  key_levels;

    modport source (output valid, action, key_index, key_levels, input ready);
    modport sink   (input valid, action, key_index, key_levels, output ready);
endinterface : kslp_cmd_if

interface kslp_rsp_if;
    import kslp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] event_code;
    logic              has_event;

    modport source (output valid, event_code, has_event, input ready);
    modport sink   (input valid, event_code, has_event, output ready);
endinterface : kslp_rsp_if
`default_nettype wire

FILE: rtl/kslp_key.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kslp_key
// Press timer and sticky event flags of one key.
// ----------------------------------------------------------------------------
module kslp_key #(
    parameter int TICK_STEP_MS = kslp_pkg::TICK_STEP_MS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire kslp_pkg::key_cmd_t           cmd,
    input  wire logic [kslp_pkg::THR_W-1:0]   short_thr,
    input  wire logic [kslp_pkg::THR_W-1:0]   long_thr,
    output logic      [kslp_pkg::FLAGS_W-1:0] flags,
    output kslp_pkg::evt_code_t               read_code
);
    import kslp_pkg::*;

    localparam logic [TIME_W-1:0] STEP = TIME_W'(TICK_STEP_MS);

    logic [TIME_W-1:0]  time_reg, time_next;
    logic [FLAGS_W-1:0] flags_reg, flags_next;
    logic [TIME_W-1:0]  st, lt, time_inc;
    logic [FLAGS_W-1:0] tick_flags, read_flags;
    logic [TIME_W-1:0]  tick_time;

    assign st       = {1'b0, short_thr};
    assign lt       = {1'b0, long_thr};
    assign time_inc = time_reg + STEP;

    // Tick update of an enabled key
    always_comb
    begin
        tick_time  = time_reg;
        tick_flags = flags_reg;
        if (time_reg < st)
        begin
            tick_time = cmd.level ? time_inc : '0;
        end
        else if (flags_reg == '0)
        begin
            tick_flags[FLAG_FIRST] = 1'b1;
            tick_flags[FLAG_SHOLD] = 1'b1;
        end
        else if (!cmd.long_mode)
        begin
            if (cmd.level)
            begin
                tick_flags[FLAG_SHOLD] = 1'b1;
            end
            else
            begin
                tick_time             = '0;
                tick_flags[FLAG_SREL] = 1'b1;
            end
        end
        else if (time_reg < lt)
        begin
            if (cmd.level)
            begin
                tick_time = time_inc;
            end
            else
            begin
                tick_time             = '0;
                tick_flags[FLAG_SREL] = 1'b1;
            end
        end
        else
        begin
            if (cmd.level)
            begin
                tick_flags[FLAG_LHOLD] = 1'b1;
            end
            else
            begin
                tick_time             = '0;
                tick_flags[FLAG_LREL] = 1'b1;
            end
        end
    end

    // Pick the highest-priority event; retire it unless a hold has no later event
    always_comb
    begin
        read_code  = EVT_NONE;
        read_flags = flags_reg;
        if (flags_reg[FLAG_FIRST])
        begin
            read_code              = EVT_FIRST;
            read_flags[FLAG_FIRST] = 1'b0;
        end
        else if (flags_reg[FLAG_SHOLD])
        begin
            read_code = EVT_SHOLD;
            if (flags_reg[FLAG_SREL] || flags_reg[FLAG_LREL] || flags_reg[FLAG_LHOLD])
            begin
                read_flags[FLAG_SHOLD] = 1'b0;
            end
        end
        else if (flags_reg[FLAG_LHOLD])
        begin
            read_code = EVT_LHOLD;
            if (flags_reg[FLAG_SREL] || flags_reg[FLAG_LREL])
            begin
                read_flags[FLAG_LHOLD] = 1'b0;
            end
        end
        else if (flags_reg[FLAG_SREL] || flags_reg[FLAG_LREL])
        begin
            read_code  = flags_reg[FLAG_SREL] ? EVT_SREL : EVT_LREL;
            read_flags = '0;
        end
    end

    always_comb
    begin
        time_next  = time_reg;
        flags_next = flags_reg;
        if (cmd.tick)
        begin
            if (cmd.enable)
            begin
                time_next  = tick_time;
                flags_next = tick_flags;
            end
            else
            begin
                flags_next = '0;
            end
        end
        else if (cmd.read)
        begin
            flags_next = read_flags;
        end
        else if (cmd.clear)
        begin
            time_next  = '0;
            flags_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            time_reg  <= time_next;
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule : kslp_key
`default_nettype wire

FILE: rtl/key_short_long_press_detector_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_short_long_press_detector_core
// Qualifies up to four push keys into short/long press events.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake     Payload
//  cmd      in   valid/ready   action, key_index, key_levels
//  rsp      out  valid/ready   event_code, has_event (read and check only)
//  APB      in   psel/penable  paddr, pwdata, prdata (64-bit registers, 8*i)
//
//  One command transfer per cycle. Key state updates at the accepting edge;
//  read and check results land in a single result register the same edge.
//  cmd.ready drops only while a result is held and rsp.ready is low.
//  Reset clears key timers, event flags, configuration and the result valid.
// ----------------------------------------------------------------------------
module key_short_long_press_detector_core #(
    parameter int NUM_KEYS     = kslp_pkg::NUM_KEYS_DEF,
    parameter int TICK_STEP_MS = kslp_pkg::TICK_STEP_MS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    kslp_cmd_if.sink                               cmd,
    kslp_rsp_if.source                             rsp,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [kslp_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [kslp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [kslp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import kslp_pkg::*;

    // Configuration registers
    logic [MAX_KEYS-1:0]         enable_reg;
    logic [MAX_KEYS-1:0]         long_mode_reg;
    logic [MAX_KEYS*THR_W-1:0]   short_thr_reg;
    logic [MAX_KEYS*THR_W-1:0]   long_thr_reg;
    logic                        cfg_wr;
    reg_idx_t                    cfg_idx;

    // Result register
    logic              rsp_valid_reg, rsp_valid_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              has_reg, has_next;

    logic    accept;
    action_t action;
    logic    key_ok;

    key_cmd_t            key_cmd   [NUM_KEYS];
    logic [FLAGS_W-1:0]  key_flags [NUM_KEYS];
    evt_code_t           key_code  [NUM_KEYS];

    logic [CODE_W-1:0] sel_code;
    logic              sel_any;

    // APB: write on the access phase; no wait states
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= '0;
            long_mode_reg <= '0;
            short_thr_reg <= '0;
            long_thr_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ENABLE:    enable_reg    <= pwdata[MAX_KEYS-1:0];
                REG_LONG_MODE: long_mode_reg <= pwdata[MAX_KEYS-1:0];
                REG_SHORT_THR: short_thr_reg <= pwdata;
                REG_LONG_THR:  long_thr_reg  <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ENABLE:    prdata = CFG_DATA_W'(enable_reg);
            REG_LONG_MODE: prdata = CFG_DATA_W'(long_mode_reg);
            REG_SHORT_THR: prdata = short_thr_reg;
            REG_LONG_THR:  prdata = long_thr_reg;
            default:       prdata = '0;
        endcase
    end

    // Hold new commands only while an untaken result sits in the register
    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign action    = action_t'(cmd.action);
    assign key_ok    = ({1'b0, cmd.key_index} < (KEY_IDX_W+1)'(NUM_KEYS));

    // One timer/flag unit per key; ticks hit all keys, others only the addressed one
    for (genvar i = 0; i < NUM_KEYS; i++)
    begin : g_key
        logic hit;
        assign hit = accept && (cmd.key_index == KEY_IDX_W'(i));

        always_comb
        begin
            key_cmd[i].tick      = accept && (action == ACT_TICK);
            key_cmd[i].level     = cmd.key_levels[i];
            key_cmd[i].enable    = enable_reg[i];
            key_cmd[i].long_mode = long_mode_reg[i];
            key_cmd[i].read      = hit && (action == ACT_READ);
            key_cmd[i].clear     = hit && (action == ACT_RESET);
        end

        kslp_key #(
            .TICK_STEP_MS (TICK_STEP_MS)
        ) u_key (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (key_cmd[i]),
            .short_thr (short_thr_reg[THR_W*i +: THR_W]),
            .long_thr  (long_thr_reg[THR_W*i +: THR_W]),
            .flags     (key_flags[i]),
            .read_code (key_code[i])
        );
    end

    // Select the addressed key's code and pending status
    always_comb
    begin
        sel_code = EVT_NONE;
        sel_any  = 1'b0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (cmd.key_index == KEY_IDX_W'(i))
            begin
                sel_code = key_code[i];
                sel_any  = (key_flags[i] != '0);
            end
        end
    end

    // Load a result on read or check; drop the valid once the sink takes it
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        code_next      = code_reg;
        has_next       = has_reg;
        if (accept && (action == ACT_READ))
        begin
            rsp_valid_next = 1'b1;
            code_next      = key_ok ? sel_code : EVT_NONE;
            has_next       = 1'b0;
        end
        else if (accept && (action == ACT_CHECK))
        begin
            rsp_valid_next = 1'b1;
            code_next      = EVT_NONE;
            has_next       = key_ok && sel_any;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        has_reg  <= has_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.event_code = code_reg;
    assign rsp.has_event  = has_reg;

endmodule : key_short_long_press_detector_core
`default_nettype wire
